// ----- hw/rtl/fastq_junction_trimmer_defines.svh -----
// Assertion macros used by the trimmer controller.
`ifndef FASTQ_JUNCTION_TRIMMER_DEFINES_SVH
`define FASTQ_JUNCTION_TRIMMER_DEFINES_SVH
`define FJT_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define FJT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/fjt_pkg.sv -----
// Shared types and constants of the junction trimmer.
package fjt_pkg;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_START = 2'd1;
  localparam logic [1:0] ERR_PLUS = 2'd2;
  localparam logic [2:0] REG_LO = 3'd0;
  localparam logic [2:0] REG_MLO = 3'd1;
  localparam logic [2:0] REG_MHI = 3'd2;
  localparam logic [2:0] REG_HI = 3'd3;
  localparam logic [2:0] REG_LEN = 3'd4;
  localparam logic [2:0] REG_OFF = 3'd5;

  typedef struct packed {
    logic [7:0] out_byte;
    logic record_end;
    logic [1:0] error_code;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic emit;        // push one item from emit_sel source
    logic [1:0] emit_sel;  // 0 direct, 1 window head
    out_item_t direct;
    logic start_seq;
    logic push_base;   // store base in window
    logic pop_head;    // drop window head
    logic clear_win;
    logic set_match;
    logic inc_seq;
    logic inc_qual;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;    // output register holds an item not yet taken
    logic match_found;
    logic full;        // next push brings pending to pattern length
    logic hit;
    logic empty;
    logic seq_cap;
    logic qual_cap;
    logic qual_keep;
    logic seq_keep;
    logic head_keep;   // head index below offset
  } dp_stat_t;

  localparam logic [1:0] SEL_DIRECT = 2'd0;
  localparam logic [1:0] SEL_HEAD = 2'd1;
endpackage

// ----- hw/rtl/fjt_stream_if.sv -----
// Valid/ready stream interface.
interface fjt_stream_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/fjt_datapath.sv -----
// Datapath: window, counters, pattern compare, output register.
module fjt_datapath import fjt_pkg::*; #(
  parameter int MAX_READ_LEN = 1023,
  parameter int MAX_PATTERN = 32
) (
  input logic clk,
  input logic rst,
  input logic [7:0] base,
  input logic [255:0] pattern,
  input logic [5:0] jlen,
  input logic [9:0] keep_off,
  input dp_cmd_t cmd,
  output dp_stat_t stat,
  output logic out_valid,
  input logic out_ready,
  output out_item_t out_item
);
  localparam int CW = $clog2(MAX_READ_LEN + 1);
  logic [7:0] win [32];
  logic [5:0] pend, plen, head;
  logic [CW-1:0] seq_count, qual_count;
  logic [CW+10:0] cut_length;
  logic match_found;
  logic [31:0] eq;
  logic [5:0] jl_c;

  assign jl_c = (jlen > 6'(MAX_PATTERN)) ? 6'(MAX_PATTERN) : jlen;

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      eq[k] = (k >= plen) || (win[k] == pattern[k*8 +: 8]);
    end
  end

  assign stat.out_busy = out_valid && !out_ready;
  assign stat.match_found = match_found;
  assign stat.full = (pend + 6'd1) >= plen;
  assign stat.hit = &eq;
  assign stat.empty = head >= pend;
  assign stat.seq_cap = seq_count >= CW'(MAX_READ_LEN);
  assign stat.qual_cap = qual_count >= CW'(MAX_READ_LEN);
  assign stat.qual_keep = !match_found || ((CW+11)'(qual_count) < cut_length);
  assign stat.seq_keep = (CW+11)'(seq_count) < cut_length;
  assign stat.head_keep = {4'd0, head} < keep_off;

  always_ff @(posedge clk) begin
    if (cmd.push_base) win[pend[4:0]] <= base;
    if (cmd.pop_head && !match_found) begin
      for (int k = 0; k < 31; k++) win[k] <= win[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0; plen <= '0; head <= '0; seq_count <= '0; qual_count <= '0;
      cut_length <= '0; match_found <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        out_item <= (cmd.emit_sel == SEL_HEAD) ?
          '{out_byte: win[head[4:0]], record_end: 1'b0, error_code: ERR_NONE} : cmd.direct;
      end
      if (cmd.start_seq) begin
        plen <= jl_c; seq_count <= '0; qual_count <= '0; pend <= '0; head <= '0;
        match_found <= (jl_c == 6'd0);
        cut_length <= (CW+11)'(keep_off);
      end
      if (cmd.inc_seq) seq_count <= seq_count + CW'(1);
      if (cmd.inc_qual) qual_count <= qual_count + CW'(1);
      if (cmd.push_base) pend <= pend + 6'd1;
      if (cmd.set_match) begin
        match_found <= 1'b1;
        cut_length <= (CW+11)'(seq_count) - (CW+11)'(plen) + (CW+11)'(keep_off);
      end
      if (cmd.pop_head) begin
        if (match_found) head <= head + 6'd1;
        else pend <= pend - 6'd1;
      end
      if (cmd.clear_win) begin pend <= '0; head <= '0; end
    end
  end
endmodule

// ----- hw/rtl/fjt_control.sv -----
// Parsing controller of the trimmer.
module fjt_control import fjt_pkg::*; #(
  parameter int MAX_NAME_LEN = 255
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [7:0] in_byte,
  output logic [7:0] base,
  input dp_stat_t stat,
  output dp_cmd_t cmd
);
  `include "fastq_junction_trimmer_defines.svh"
  localparam int IW = $clog2(MAX_NAME_LEN + 1);
  typedef enum logic [8:0] {
    S_START = 9'b000000001, S_ID = 9'b000000010, S_DESC = 9'b000000100,
    S_SEQ = 9'b000001000, S_PLUS = 9'b000010000, S_PLINE = 9'b000100000,
    S_QUAL = 9'b001000000, S_DRAIN = 9'b010000000, S_HALT = 9'b100000000
  } state_t;
  state_t state, state_next;
  logic [IW-1:0] id_count;
  logic drain_match, drain_match_next;
  logic ws, acc, busy;

  assign ws = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
  assign busy = stat.out_busy;
  assign in_ready = !busy && !(state == S_DRAIN || state == S_HALT);
  assign acc = in_valid && in_ready;
  assign base = (in_byte >= 8'h61 && in_byte <= 8'h7A) ? in_byte - 8'd32 : in_byte;

  function automatic out_item_t item(logic [7:0] b, logic r, logic [1:0] e);
    return '{out_byte: b, record_end: r, error_code: e};
  endfunction

  always_comb begin
    state_next = state;
    drain_match_next = drain_match;
    cmd = '0;
    cmd.emit_sel = SEL_DIRECT;
    unique case (state)
      S_START: if (acc) begin
        cmd.emit = 1'b1;
        if (in_byte == CH_AT) begin
          cmd.direct = item(CH_AT, 1'b0, ERR_NONE); state_next = S_ID;
        end else begin
          cmd.direct = item(8'd0, 1'b0, ERR_START); state_next = S_HALT;
        end
      end
      S_ID, S_DESC: if (acc) begin
        if (in_byte == CH_NL) begin
          cmd.emit = 1'b1; cmd.direct = item(CH_NL, 1'b0, ERR_NONE);
          cmd.start_seq = 1'b1; state_next = S_SEQ;
        end else if (state == S_ID) begin
          if (ws || 32'(id_count) >= MAX_NAME_LEN) state_next = S_DESC;
          else begin
            cmd.emit = 1'b1; cmd.direct = item(in_byte, 1'b0, ERR_NONE);
          end
        end
      end
      S_SEQ: if (acc) begin
        if (in_byte == CH_NL) begin
          drain_match_next = 1'b0; state_next = S_DRAIN;
        end else if (!ws && !stat.seq_cap) begin
          cmd.inc_seq = 1'b1;
          if (stat.match_found) begin
            if (stat.seq_keep) begin
              cmd.emit = 1'b1; cmd.direct = item(base, 1'b0, ERR_NONE);
            end
          end else begin
            cmd.push_base = 1'b1;
            if (stat.full) begin
              drain_match_next = 1'b1; state_next = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: if (!busy) begin
        if (drain_match) begin
          // Window is complete: compare once, then either cut or shift by one.
          if (stat.match_found) begin
            if (stat.empty || !stat.head_keep) begin
              cmd.clear_win = 1'b1; state_next = S_SEQ;
            end else begin
              cmd.emit = 1'b1; cmd.emit_sel = SEL_HEAD; cmd.pop_head = 1'b1;
            end
          end else if (stat.hit) cmd.set_match = 1'b1;
          else begin
            cmd.emit = 1'b1; cmd.emit_sel = SEL_HEAD; cmd.pop_head = 1'b1;
            state_next = S_SEQ;
          end
        end else if (stat.empty) begin
          cmd.emit = 1'b1; cmd.direct = item(CH_NL, 1'b0, ERR_NONE);
          cmd.clear_win = 1'b1; state_next = S_PLUS;
        end else begin
          cmd.emit = 1'b1; cmd.emit_sel = SEL_HEAD; cmd.pop_head = 1'b1;
        end
      end
      S_PLUS: if (acc) begin
        cmd.emit = 1'b1;
        if (in_byte == CH_PLUS) begin
          cmd.direct = item(CH_PLUS, 1'b0, ERR_NONE); state_next = S_PLINE;
        end else begin
          cmd.direct = item(8'd0, 1'b0, ERR_PLUS); state_next = S_HALT;
        end
      end
      S_PLINE: if (acc && in_byte == CH_NL) begin
        cmd.emit = 1'b1; cmd.direct = item(CH_NL, 1'b0, ERR_NONE); state_next = S_QUAL;
      end
      S_QUAL: if (acc) begin
        if (in_byte == CH_NL) begin
          cmd.emit = 1'b1; cmd.direct = item(CH_NL, 1'b1, ERR_NONE); state_next = S_START;
        end else if (!ws && !stat.qual_cap) begin
          cmd.inc_qual = 1'b1;
          if (stat.qual_keep) begin
            cmd.emit = 1'b1; cmd.direct = item(in_byte, 1'b0, ERR_NONE);
          end
        end
      end
      S_HALT: ;
      default: state_next = S_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START; id_count <= '0; drain_match <= 1'b0;
    end else begin
      state <= state_next; drain_match <= drain_match_next;
      if (state == S_START && acc) id_count <= '0;
      else if (state == S_ID && acc && cmd.emit && in_byte != CH_NL)
        id_count <= id_count + IW'(1);
    end
  end

  `FJT_ASSERT_IMPL(a_no_emit_busy, clk, rst, busy, !cmd.emit)
  `FJT_ASSERT_IMPL(a_halt_ready, clk, rst, state == S_HALT, !in_ready)
  `FJT_ASSERT_NEXT(a_err_halts, clk, rst, cmd.emit && cmd.direct.error_code != ERR_NONE
    && cmd.emit_sel == SEL_DIRECT, state == S_HALT)
endmodule

// ----- hw/rtl/fastq_junction_trimmer.sv -----
// Top level of the FASTQ junction trimmer.
// One input byte is taken per cycle while the output register is free. Once the pattern
// window is full and no match has been found, each further base is followed by a compare
// step in the drain state. A match records the cut, emits each kept window base (up to 32)
// and then clears the window. The end of a sequence line flushes the pending bases at one
// per cycle (up to 31) while the output is not stalled, then emits the newline. The input is
// stalled during all of these. A stall on the output side holds the input for as long. After
// an error the block halts until reset.
module fastq_junction_trimmer import fjt_pkg::*; #(
  parameter int MAX_READ_LEN = 1023,
  parameter int MAX_NAME_LEN = 255,
  parameter int MAX_PATTERN = 32
) (
  input logic clk,
  input logic rst,
  fjt_stream_if.sink in_ch,
  fjt_stream_if.source out_ch,
  input logic cfg_valid,
  output logic cfg_ready,
  input logic [2:0] cfg_index,
  input logic [63:0] cfg_data
);
  logic [255:0] pattern;
  logic [5:0] jlen;
  logic [9:0] keep_off;
  logic [7:0] base;
  dp_cmd_t cmd;
  dp_stat_t stat;
  out_item_t item;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0; jlen <= '0; keep_off <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LO: pattern[63:0] <= cfg_data;
        REG_MLO: pattern[127:64] <= cfg_data;
        REG_MHI: pattern[191:128] <= cfg_data;
        REG_HI: pattern[255:192] <= cfg_data;
        REG_LEN: jlen <= cfg_data[5:0];
        REG_OFF: keep_off <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  fjt_control #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_ctl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.data[7:0]),
    .base, .stat, .cmd
  );
  fjt_datapath #(.MAX_READ_LEN(MAX_READ_LEN), .MAX_PATTERN(MAX_PATTERN)) u_dp (
    .clk, .rst, .base, .pattern, .jlen, .keep_off, .cmd, .stat,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(item)
  );
  assign out_ch.data = item;
endmodule
